// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL that carries concurrent checks.
// No dependencies; included by the top level of the rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/rpe_pkg.sv =====
// Shared constants and the elaboration-time sine table generator.
// No dependencies; used by rpe_rot_stage and the top level.
package rpe_pkg;

    localparam int COORD_W              = 32;
    localparam int ANGLE_W              = 16;
    localparam int SINE_TABLE_BITS_DEF  = 10;
    localparam int SINE_FRAC_BITS_DEF   = 15;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave sine entry k for a table of 2^tb steps, with fb fraction bits.
    // Only evaluated at elaboration to fill the constant table.
    function automatic logic [31:0] quarter_sine(input int unsigned k,
                                                 input int unsigned tb,
                                                 input int unsigned fb);
        logic [63:0] n;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int unsigned sh;
        n    = 64'd1 << tb;
        x    = (64'(k) * HALF_PI_Q30 + (n >> 1)) >> tb;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        sh   = 30 - fb;
        // Taylor series terms, each divided by (2n)(2n+1), with alternating signs.
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        if (sh == 0) begin
            return 32'(sum);
        end
        return 32'((64'(sum) + (64'd1 << (sh - 1))) >> sh);
    endfunction

endpackage

// ===== hw/rtl/rpe_rot_stage.sv =====
// One planar rotation: sine/cosine lookup, split multiplies, rounded sums.
// Depends on rpe_pkg for the table generator.
module rpe_rot_stage #(
    parameter int IN_W       = 33,
    parameter int TABLE_BITS = rpe_pkg::SINE_TABLE_BITS_DEF,
    parameter int FRAC_BITS  = rpe_pkg::SINE_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [IN_W-1:0]        a_in,
    input  logic signed [IN_W-1:0]        b_in,
    input  logic [rpe_pkg::ANGLE_W-1:0]   angle_in,
    output logic signed [IN_W+1:0]        ra_out,   // round((a*c - b*s) / 2^F)
    output logic signed [IN_W+1:0]        rb_out    // round((b*c + a*s) / 2^F)
);

    localparam int OUT_W = IN_W + 2;
    localparam int N     = 1 << TABLE_BITS;
    localparam int IDX_W = TABLE_BITS + 1;
    localparam int CS_W  = FRAC_BITS + 2;
    localparam int HI_W  = IN_W - 16;
    localparam int HP_W  = HI_W + CS_W;
    localparam int LP_W  = 17 + CS_W;
    localparam int SUM_W = IN_W + FRAC_BITS + 3;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

    // Quarter-wave sine table, constant after elaboration.
    logic [FRAC_BITS:0] sine_rom [0:N];
    for (genvar k = 0; k <= N; k++) begin : g_rom
        localparam logic [FRAC_BITS:0] ENTRY =
            (FRAC_BITS + 1)'(rpe_pkg::quarter_sine(k, TABLE_BITS, FRAC_BITS));
        assign sine_rom[k] = ENTRY;
    end

    logic [IDX_W-1:0] idx_lo;
    logic [IDX_W-1:0] idx_hi;
    assign idx_lo = {1'b0, angle_in[13 -: TABLE_BITS]};
    assign idx_hi = IDX_W'(N) - idx_lo;

    // Stage 1: table reads and operand capture.
    logic [FRAC_BITS:0]     lo_reg, hi_reg;
    logic [1:0]             quad_reg;
    logic signed [IN_W-1:0] a1_reg, b1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg   <= sine_rom[idx_lo];
            hi_reg   <= sine_rom[idx_hi];
            quad_reg <= angle_in[15:14];
            a1_reg   <= a_in;
            b1_reg   <= b_in;
        end
    end

    // Quadrant folding of the table values into signed sine and cosine.
    logic signed [CS_W-1:0] lo_s, hi_s, sin_v, cos_v;
    assign lo_s = signed'({1'b0, lo_reg});
    assign hi_s = signed'({1'b0, hi_reg});

    always_comb begin
        unique case (quad_reg)
            2'd0: begin sin_v = lo_s;  cos_v = hi_s;  end
            2'd1: begin sin_v = hi_s;  cos_v = -lo_s; end
            2'd2: begin sin_v = -lo_s; cos_v = -hi_s; end
            default: begin sin_v = -hi_s; cos_v = lo_s; end
        endcase
    end

    // Operands split into a signed high part and an unsigned low 16 bits.
    logic signed [HI_W-1:0] a_hi, b_hi;
    logic signed [16:0]     a_lo, b_lo;
    assign a_hi = a1_reg[IN_W-1:16];
    assign b_hi = b1_reg[IN_W-1:16];
    assign a_lo = signed'({1'b0, a1_reg[15:0]});
    assign b_lo = signed'({1'b0, b1_reg[15:0]});

    // Stage 2: partial products.
    logic signed [HP_W-1:0] ahc_reg, bhs_reg, bhc_reg, ahs_reg;
    logic signed [LP_W-1:0] alc_reg, bls_reg, blc_reg, als_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ahc_reg <= a_hi * cos_v;
            bhs_reg <= b_hi * sin_v;
            bhc_reg <= b_hi * cos_v;
            ahs_reg <= a_hi * sin_v;
            alc_reg <= a_lo * cos_v;
            bls_reg <= b_lo * sin_v;
            blc_reg <= b_lo * cos_v;
            als_reg <= a_lo * sin_v;
        end
    end

    // Stage 3: recombine, add half and floor by the fraction width.
    logic signed [SUM_W-1:0] ra_sum, rb_sum, ra_shift, rb_shift;
    logic signed [OUT_W-1:0] ra_next, rb_next, ra_reg, rb_reg;

    always_comb begin
        ra_sum   = ((SUM_W'(ahc_reg) - SUM_W'(bhs_reg)) <<< 16)
                 + SUM_W'(alc_reg) - SUM_W'(bls_reg) + ROUND_HALF;
        rb_sum   = ((SUM_W'(bhc_reg) + SUM_W'(ahs_reg)) <<< 16)
                 + SUM_W'(blc_reg) + SUM_W'(als_reg) + ROUND_HALF;
        ra_shift = ra_sum >>> FRAC_BITS;
        rb_shift = rb_sum >>> FRAC_BITS;
        ra_next  = ra_shift[OUT_W-1:0];
        rb_next  = rb_shift[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end

    assign ra_out = ra_reg;
    assign rb_out = rb_reg;

endmodule

// ===== hw/rtl/rotate_point_euler_about_center_top.sv =====
// Channel   Dir  Fields (tdata, lowest bit first)
// s_axis    in   point_x,y,z, center_x,y,z (32b each), angle_x,y,z (16b each)
// m_axis    out  rotated_x, rotated_y, rotated_z (32b each)
//
// One point enters per cycle unless m_axis stalls; each point passes center subtraction,
// three rotations (lookup, partial products, rounded sum) and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on m_axis freezes the whole pipeline, and s_tready follows it.
// Depends on rpe_pkg, rpe_rot_stage and assert_macros.svh.
`include "assert_macros.svh"

module rotate_point_euler_about_center_top #(
    parameter int SINE_TABLE_BITS = rpe_pkg::SINE_TABLE_BITS_DEF,
    parameter int SINE_FRAC_BITS  = rpe_pkg::SINE_FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, center_x, center_y, center_z, angle_x, angle_y, angle_z
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [95:0]  m_tdata
);

    localparam int CW    = rpe_pkg::COORD_W;
    localparam int AW    = rpe_pkg::ANGLE_W;
    localparam int W0    = CW + 1;
    localparam int W1    = W0 + 2;
    localparam int W2    = W1 + 2;
    localparam int W3    = W2 + 2;
    localparam int DEPTH = 11;
    localparam int LAST  = DEPTH - 1;
    localparam logic signed [W3:0] SAT_MAX = (W3 + 1)'(64'sd2147483647);
    localparam logic signed [W3:0] SAT_MIN = (W3 + 1)'(-64'sd2147483648);

    // Global advance: the pipeline moves unless a finished result is held.
    logic en;
    logic [DEPTH-1:0] valid_reg;
    assign en       = !valid_reg[LAST] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[LAST];

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // Input fields.
    logic signed [CW-1:0] px, py, pz, cx, cy, cz;
    assign px = s_tdata[31:0];
    assign py = s_tdata[63:32];
    assign pz = s_tdata[95:64];
    assign cx = s_tdata[127:96];
    assign cy = s_tdata[159:128];
    assign cz = s_tdata[191:160];

    // Stage 0: center subtraction.
    logic signed [W0-1:0] x0_reg, y0_reg, z0_reg;
    logic [AW-1:0]        ax0_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg  <= W0'(px) - W0'(cx);
            y0_reg  <= W0'(py) - W0'(cy);
            z0_reg  <= W0'(pz) - W0'(cz);
            ax0_reg <= s_tdata[207:192];
        end
    end

    // Delay lines for values consumed later in the pipeline.
    logic signed [CW-1:0] cx_dly_reg [0:9], cy_dly_reg [0:9], cz_dly_reg [0:9];
    logic [AW-1:0]        ay_dly_reg [0:3], az_dly_reg [0:6];
    logic signed [W0-1:0] x_dly_reg  [0:2];
    logic signed [W1-1:0] ty_dly_reg [0:2];
    logic signed [W2-1:0] nz_dly_reg [0:2];

    logic signed [W1-1:0] ty, tz;
    logic signed [W2-1:0] nz, tx;
    logic signed [W3-1:0] nx, ny;

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_dly_reg[0] <= cx;
            cy_dly_reg[0] <= cy;
            cz_dly_reg[0] <= cz;
            for (int i = 1; i < 10; i++) begin
                cx_dly_reg[i] <= cx_dly_reg[i-1];
                cy_dly_reg[i] <= cy_dly_reg[i-1];
                cz_dly_reg[i] <= cz_dly_reg[i-1];
            end
            ay_dly_reg[0] <= s_tdata[223:208];
            az_dly_reg[0] <= s_tdata[239:224];
            for (int i = 1; i < 4; i++) begin
                ay_dly_reg[i] <= ay_dly_reg[i-1];
            end
            for (int i = 1; i < 7; i++) begin
                az_dly_reg[i] <= az_dly_reg[i-1];
            end
            x_dly_reg[0]  <= x0_reg;
            ty_dly_reg[0] <= ty;
            nz_dly_reg[0] <= nz;
            for (int i = 1; i < 3; i++) begin
                x_dly_reg[i]  <= x_dly_reg[i-1];
                ty_dly_reg[i] <= ty_dly_reg[i-1];
                nz_dly_reg[i] <= nz_dly_reg[i-1];
            end
        end
    end

    // Rotation about X: (y, z) -> (ty, tz).
    rpe_rot_stage #(.IN_W(W0), .TABLE_BITS(SINE_TABLE_BITS), .FRAC_BITS(SINE_FRAC_BITS))
        u_rot_x (.aclk(aclk), .en(en), .a_in(y0_reg), .b_in(z0_reg),
                 .angle_in(ax0_reg), .ra_out(ty), .rb_out(tz));

    // Rotation about Y: (tz, x) -> (nz, tx).
    rpe_rot_stage #(.IN_W(W1), .TABLE_BITS(SINE_TABLE_BITS), .FRAC_BITS(SINE_FRAC_BITS))
        u_rot_y (.aclk(aclk), .en(en), .a_in(tz), .b_in(W1'(x_dly_reg[2])),
                 .angle_in(ay_dly_reg[3]), .ra_out(nz), .rb_out(tx));

    // Rotation about Z: (tx, ty) -> (nx, ny).
    rpe_rot_stage #(.IN_W(W2), .TABLE_BITS(SINE_TABLE_BITS), .FRAC_BITS(SINE_FRAC_BITS))
        u_rot_z (.aclk(aclk), .en(en), .a_in(tx), .b_in(W2'(ty_dly_reg[2])),
                 .angle_in(az_dly_reg[6]), .ra_out(nx), .rb_out(ny));

    // Output stage: add the center back and saturate to Q16.16.
    logic signed [W3:0]   sx, sy, sz;
    logic signed [CW-1:0] ox_next, oy_next, oz_next;
    logic [95:0]          out_reg;

    always_comb begin
        sx = (W3 + 1)'(nx) + (W3 + 1)'(cx_dly_reg[9]);
        sy = (W3 + 1)'(ny) + (W3 + 1)'(cy_dly_reg[9]);
        sz = (W3 + 1)'(nz_dly_reg[2]) + (W3 + 1)'(cz_dly_reg[9]);
        ox_next = (sx > SAT_MAX) ? CW'(SAT_MAX) : (sx < SAT_MIN) ? CW'(SAT_MIN) : CW'(sx);
        oy_next = (sy > SAT_MAX) ? CW'(SAT_MAX) : (sy < SAT_MIN) ? CW'(SAT_MIN) : CW'(sy);
        oz_next = (sz > SAT_MAX) ? CW'(SAT_MAX) : (sz < SAT_MIN) ? CW'(SAT_MIN) : CW'(sz);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= {oz_next, oy_next, ox_next};
        end
    end

    assign m_tdata = out_reg;

    // A held result must block new requests; an empty output never blocks.
    `ASSERT_CLK(a_stall_blocks_input, aclk, aresetn, (m_tvalid && !m_tready) |-> !s_tready, "input accepted while output stalled")
    `ASSERT_CLK(a_empty_never_blocks, aclk, aresetn, !m_tvalid |-> s_tready, "input blocked with empty output")
    `ASSERT_CLK_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule
